// ===== rtl/fmod_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmod_pkg
// Shared constants and types for the floored signed modulo pipeline.
// ----------------------------------------------------------------------------
package fmod_pkg;

    localparam int DATA_W = 64;
    localparam int WIDTH  = 64;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic             valid;
        logic [WIDTH-1:0] rem;
        logic [WIDTH-1:0] num;
        logic [WIDTH-1:0] den;
        logic             an;
        logic             bn;
        logic             bz;
    } t_stage;

endpackage
`default_nettype wire

// ===== rtl/fmod_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmod_in_if / fmod_out_if
// Valid/ready channels carrying the operands and the remainder.
// ----------------------------------------------------------------------------
interface fmod_in_if;
    logic                  valid;
    logic                  ready;
    fmod_pkg::t_data       dividend;
    fmod_pkg::t_data       divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface fmod_out_if;
    logic                  valid;
    logic                  ready;
    fmod_pkg::t_data       remainder;

    modport source (output valid, output remainder, input ready);
    modport sink   (input valid, input remainder, output ready);
endinterface
`default_nettype wire

// ===== rtl/floored_modulo_int64.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// floored_modulo_int64
// Pipelined floored signed modulo with the sign of the divisor.
// ----------------------------------------------------------------------------
// The block accepts one transaction per cycle and returns each remainder
// through registered stages: a prep stage forms the operand magnitudes, one
// restoring division step per operand bit follows, and a final fixup stage
// applies the sign rules. A zero divisor gives a remainder of zero. When the
// output is not taken, the whole pipeline holds and the input is not ready.
module floored_modulo_int64 (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fmod_in_if.sink     i_in,
    fmod_out_if.source  o_out
);
    import fmod_pkg::*;

    logic   en;
    logic   out_valid;
    t_stage stage [0:WIDTH];

    assign en         = !out_valid || o_out.ready;
    assign i_in.ready = en;
    assign o_out.valid = out_valid;

    fmod_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in.valid),
        .i_dividend (i_in.dividend),
        .i_divisor  (i_in.divisor),
        .o_stage    (stage[0])
    );

    for (genvar g = 0; g < WIDTH; g++) begin : g_div
        fmod_div_stage u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (stage[g]),
            .o_stage (stage[g+1])
        );
    end

    fmod_fixup u_fixup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_stage     (stage[WIDTH]),
        .o_valid     (out_valid),
        .o_remainder (o_out.remainder)
    );
endmodule
`default_nettype wire

// ===== rtl/fmod_prep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmod_prep
// Entry stage: extracts operand signs and unsigned magnitudes.
// ----------------------------------------------------------------------------
module fmod_prep (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  fmod_pkg::t_data  i_dividend,
    input  fmod_pkg::t_data  i_divisor,
    output fmod_pkg::t_stage o_stage
);
    import fmod_pkg::*;

    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    t_stage           r_stage;
    t_stage           n_stage;

    assign a = i_dividend[WIDTH-1:0];
    assign b = i_divisor[WIDTH-1:0];

    always_comb begin
        n_stage.valid = i_valid;
        n_stage.rem   = '0;
        n_stage.an    = a[WIDTH-1];
        n_stage.bn    = b[WIDTH-1];
        n_stage.bz    = (b == '0);
        n_stage.num   = a[WIDTH-1] ? (WIDTH'(0) - a) : a;
        n_stage.den   = b[WIDTH-1] ? (WIDTH'(0) - b) : b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;
endmodule
`default_nettype wire

// ===== rtl/fmod_div_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmod_div_stage
// One restoring division step: shifts in one dividend bit and subtracts
// the divisor magnitude when the partial remainder allows it.
// ----------------------------------------------------------------------------
module fmod_div_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  fmod_pkg::t_stage i_stage,
    output fmod_pkg::t_stage o_stage
);
    import fmod_pkg::*;

    logic [WIDTH:0] trial;
    logic [WIDTH:0] diff;
    t_stage         r_stage;
    t_stage         n_stage;

    assign trial = {i_stage.rem, i_stage.num[WIDTH-1]};
    assign diff  = trial - {1'b0, i_stage.den};

    always_comb begin
        n_stage     = i_stage;
        n_stage.num = {i_stage.num[WIDTH-2:0], 1'b0};
        n_stage.rem = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;
endmodule
`default_nettype wire

// ===== rtl/fmod_fixup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmod_fixup
// Exit stage: applies the floored sign rules to the unsigned remainder
// and holds the result for the output channel.
// ----------------------------------------------------------------------------
module fmod_fixup (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  fmod_pkg::t_stage i_stage,
    output logic             o_valid,
    output fmod_pkg::t_data  o_remainder
);
    import fmod_pkg::*;

    logic signed [WIDTH-1:0] res;
    logic                    r_valid;
    t_data                   r_rem;

    always_comb begin
        if (i_stage.bz || (i_stage.rem == '0)) begin
            res = '0;
        end else if (i_stage.bn && i_stage.an) begin
            res = WIDTH'(0) - i_stage.rem;
        end else if (i_stage.bn) begin
            res = i_stage.rem - i_stage.den;
        end else if (i_stage.an) begin
            res = i_stage.den - i_stage.rem;
        end else begin
            res = i_stage.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
        if (i_en) begin
            r_rem <= DATA_W'(res);
        end
    end

    assign o_valid     = r_valid;
    assign o_remainder = r_rem;
endmodule
`default_nettype wire
